// File: hw/rtl/gmw_pkg.sv
// ----------------------------------------------------------------------------
// gmw_pkg: shared types and constants of the grid mesh winding indexer
// Sizes, point and sign types, and the records that travel between stages.
// ----------------------------------------------------------------------------
package gmw_pkg;

  localparam int COLS_MAX   = 64;
  localparam int ROWS_MAX   = 64;
  localparam int POS_W      = 24;
  localparam int CNT_W      = 7;
  localparam int IDX_W      = 13;
  localparam int CFG_W      = 7;
  localparam int COL_AW     = $clog2(COLS_MAX + 1);
  localparam int DIFF_W     = POS_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUB_W      = PROD_W + 1;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CRD_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    REG_GRID_COLUMNS = 1'b0,
    REG_GRID_ROWS    = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    SGN_NONE = 2'd0,
    SGN_POS  = 2'd1,
    SGN_NEG  = 2'd2
  } sign_e;

  typedef struct packed {
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } point_t;

  // Per-vertex control record that follows the cross product pipeline.
  typedef struct packed {
    logic             closing;
    logic             is_final;
    logic             pos_ok;
    logic [IDX_W-1:0] va;
    logic [IDX_W-1:0] vd;
  } item_t;

  typedef struct packed {
    item_t item;
    sign_e s0;
    sign_e s1;
  } cross_t;

  // Work for the result sequencer: one record per vertex that has results.
  typedef struct packed {
    logic             closing;
    logic             is_final;
    logic             verdict;
    logic [IDX_W-1:0] va;
    logic [IDX_W-1:0] vd;
  } job_t;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] idx;
    logic             ok;
    logic             last;
  } result_t;

  function automatic logic signed [DIFF_W-1:0] pos_diff(
    input logic signed [POS_W-1:0] p,
    input logic signed [POS_W-1:0] q
  );
    return DIFF_W'(p) - DIFF_W'(q);
  endfunction

endpackage

// File: hw/rtl/grid_mesh_winding_check_indexer.sv
// ----------------------------------------------------------------------------
// grid_mesh_winding_check_indexer: regular grid triangulation and winding check
// A cell's first index follows its closing vertex through the cross stages,
// result queue and output register. A closing vertex yields 6 indices (7
// results on the last, with the verdict); others yield none and are taken one
// per cycle while credits remain. Output, one transfer per ready cycle, sets the rate.
// Reset clears counters, winding state and queues; the line store needs none.
// ----------------------------------------------------------------------------
module grid_mesh_winding_check_indexer import gmw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  reg_idx_e             cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [2*POS_W-1:0]   s_axis_tdata,   // pos_x, pos_y
  input  logic [0:0]           s_axis_tuser,   // pos_ok
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // vertex_index, grid_ok, zero fill
  output logic [0:0]           m_axis_tuser,   // kind
  output logic                 m_axis_tlast
);

  logic [CFG_W-1:0] cols_cfg_q, rows_cfg_q;
  logic [CNT_W-1:0] col_q, row_q;
  logic [IDX_W-1:0] vtx_q;
  logic [CNT_W-1:0] cols_eff, rows_eff;

  logic             acc;
  point_t           d_pt;
  item_t            item0;

  logic             s1_valid_q;
  item_t            s1_item_q;
  point_t           s1_d_q;
  point_t           ul_q, left_q;
  point_t           b_pt;
  logic [2*POS_W-1:0] ram_rdata;

  logic             x_valid;
  cross_t           x_res;
  sign_e            ws_q, ws1, ws2;
  logic             fail_q, f0, f1, f2;
  logic             push, skip, pop;
  job_t             job;
  logic [CRD_W-1:0] crd_q;
  result_t          res;

  function automatic logic [CNT_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                               input logic [CNT_W-1:0] vmax);
    if (v == '0) begin
      return CNT_W'(1);
    end else if (CNT_W'(v) > vmax) begin
      return vmax;
    end
    return CNT_W'(v);
  endfunction

  assign cols_eff = eff_dim(cols_cfg_q, CNT_W'(COLS_MAX));
  assign rows_eff = eff_dim(rows_cfg_q, CNT_W'(ROWS_MAX));

  assign acc    = s_axis_tvalid && s_axis_tready;
  assign d_pt.x = s_axis_tdata[POS_W-1:0];
  assign d_pt.y = s_axis_tdata[2*POS_W-1:POS_W];

  assign item0.closing  = (row_q != '0) && (col_q != '0);
  assign item0.is_final = (row_q >= rows_eff) && (col_q >= cols_eff);
  assign item0.pos_ok   = s_axis_tuser[0];
  assign item0.vd       = vtx_q;
  assign item0.va       = vtx_q - IDX_W'(cols_eff) - IDX_W'(2);

  // Configuration and vertex counters; any register write restarts the grid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= CFG_W'(1);
      rows_cfg_q <= CFG_W'(1);
      col_q      <= '0;
      row_q      <= '0;
      vtx_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_GRID_COLUMNS: cols_cfg_q <= cfg_wdata_i;
        REG_GRID_ROWS:    rows_cfg_q <= cfg_wdata_i;
        default: ;
      endcase
      col_q <= '0;
      row_q <= '0;
      vtx_q <= '0;
    end else if (acc) begin
      if (item0.is_final) begin
        col_q <= '0;
        row_q <= '0;
        vtx_q <= '0;
      end else begin
        vtx_q <= vtx_q + IDX_W'(1);
        if (col_q >= cols_eff) begin
          col_q <= '0;
          row_q <= row_q + CNT_W'(1);
        end else begin
          col_q <= col_q + CNT_W'(1);
        end
      end
    end
  end

  // The line store is read and overwritten at the same column in the same cycle;
  // consecutive vertices use different columns unless a register write intervenes.
  gmw_ram #(
    .WIDTH (2 * POS_W),
    .DEPTH (COLS_MAX + 1)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (acc && !item0.is_final),
    .waddr_i (col_q[COL_AW-1:0]),
    .wdata_i (d_pt),
    .raddr_i (col_q[COL_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign b_pt = ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_item_q <= item0;
      s1_d_q    <= d_pt;
    end
    if (s1_valid_q && !s1_item_q.is_final) begin
      ul_q   <= b_pt;
      left_q <= s1_d_q;
    end
  end

  gmw_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid_q),
    .item_i  (s1_item_q),
    .a_i     (ul_q),
    .b_i     (b_pt),
    .c_i     (left_q),
    .d_i     (s1_d_q),
    .valid_o (x_valid),
    .res_o   (x_res)
  );

  // Winding check: both triangles are applied in order, failure is sticky.
  always_comb begin
    f0  = fail_q || !x_res.item.pos_ok;
    f1  = f0;
    ws1 = ws_q;
    f2  = f0;
    ws2 = ws_q;
    if (x_res.item.closing) begin
      f1  = f0 || (x_res.s0 == SGN_NONE) || ((ws_q != SGN_NONE) && (ws_q != x_res.s0));
      ws1 = f1 ? ws_q : x_res.s0;
      f2  = f1 || (x_res.s1 == SGN_NONE) || ((ws1 != SGN_NONE) && (ws1 != x_res.s1));
      ws2 = f2 ? ws1 : x_res.s1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q   <= SGN_NONE;
      fail_q <= 1'b0;
    end else if (cfg_we_i) begin
      ws_q   <= SGN_NONE;
      fail_q <= 1'b0;
    end else if (x_valid) begin
      if (x_res.item.is_final) begin
        ws_q   <= SGN_NONE;
        fail_q <= 1'b0;
      end else begin
        ws_q   <= ws2;
        fail_q <= f2;
      end
    end
  end

  assign push         = x_valid && (x_res.item.closing || x_res.item.is_final);
  assign skip         = x_valid && !push;
  assign job.closing  = x_res.item.closing;
  assign job.is_final = x_res.item.is_final;
  assign job.verdict  = !f2;
  assign job.va       = x_res.item.va;
  assign job.vd       = x_res.item.vd;

  // Credits cover every vertex between acceptance and leaving the queue,
  // so the queue can never overflow.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crd_q <= '0;
    end else begin
      crd_q <= crd_q + CRD_W'(acc) - CRD_W'(pop) - CRD_W'(skip);
    end
  end

  assign s_axis_tready = crd_q < CRD_W'(FIFO_DEPTH);

  gmw_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .job_i       (job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {2'b00, res.ok, res.idx};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

// File: hw/rtl/gmw_ram.sv
// ----------------------------------------------------------------------------
// gmw_ram: generic single-write, single-read RAM
// Registered read; a read at the address being written returns the old data.
// ----------------------------------------------------------------------------
module gmw_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/gmw_cross.sv
// ----------------------------------------------------------------------------
// gmw_cross: exact cross product sign pipeline
// Three register stages: coordinate differences, products, signed compare.
// ----------------------------------------------------------------------------
module gmw_cross import gmw_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  item_t  item_i,
  input  point_t a_i,
  input  point_t b_i,
  input  point_t c_i,
  input  point_t d_i,
  output logic   valid_o,
  output cross_t res_o
);

  logic                     va_q, vb_q, vc_q;
  item_t                    ia_q, ib_q;
  cross_t                   res_q;

  logic signed [DIFF_W-1:0] d0x1_q, d0y2_q, d0y1_q, d0x2_q;
  logic signed [DIFF_W-1:0] d1x1_q, d1y2_q, d1y1_q, d1x2_q;
  logic signed [PROD_W-1:0] m0a_q, m0b_q, m1a_q, m1b_q;
  logic signed [SUB_W-1:0]  sub0, sub1;

  function automatic sign_e sign_of(input logic signed [SUB_W-1:0] v);
    if (v == '0) begin
      return SGN_NONE;
    end else if (v[SUB_W-1]) begin
      return SGN_NEG;
    end
    return SGN_POS;
  endfunction

  assign sub0 = SUB_W'(m0a_q) - SUB_W'(m0b_q);
  assign sub1 = SUB_W'(m1a_q) - SUB_W'(m1b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // First triangle is (c-a)x(b-a), second is (c-b)x(d-b).
  always_ff @(posedge clk_i) begin
    ia_q   <= item_i;
    d0x1_q <= pos_diff(c_i.x, a_i.x);
    d0y2_q <= pos_diff(b_i.y, a_i.y);
    d0y1_q <= pos_diff(c_i.y, a_i.y);
    d0x2_q <= pos_diff(b_i.x, a_i.x);
    d1x1_q <= pos_diff(c_i.x, b_i.x);
    d1y2_q <= pos_diff(d_i.y, b_i.y);
    d1y1_q <= pos_diff(c_i.y, b_i.y);
    d1x2_q <= pos_diff(d_i.x, b_i.x);

    ib_q  <= ia_q;
    m0a_q <= d0x1_q * d0y2_q;
    m0b_q <= d0y1_q * d0x2_q;
    m1a_q <= d1x1_q * d1y2_q;
    m1b_q <= d1y1_q * d1x2_q;

    res_q.item <= ib_q;
    res_q.s0   <= sign_of(sub0);
    res_q.s1   <= sign_of(sub1);
  end

  assign valid_o = vc_q;
  assign res_o   = res_q;

endmodule

// File: hw/rtl/gmw_emit.sv
// ----------------------------------------------------------------------------
// gmw_emit: result queue and sequencer
// Queues per-vertex jobs and unrolls each into six indices and/or a verdict.
// ----------------------------------------------------------------------------
module gmw_emit import gmw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    job_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  localparam logic [2:0] STEP_A0      = 3'd0;
  localparam logic [2:0] STEP_C0      = 3'd1;
  localparam logic [2:0] STEP_B0      = 3'd2;
  localparam logic [2:0] STEP_B1      = 3'd3;
  localparam logic [2:0] STEP_C1      = 3'd4;
  localparam logic [2:0] STEP_D       = 3'd5;
  localparam logic [2:0] STEP_VERDICT = 3'd6;

  job_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q;
  logic [CRD_W-1:0]   count_q;
  logic [2:0]         step_q;
  logic               out_valid_q;
  result_t            out_q;

  job_t               head;
  logic [2:0]         sel;
  logic               load_ok;
  logic               fire;
  logic               done;
  result_t            res;

  assign head    = fifo_q[rptr_q];
  assign load_ok = !out_valid_q || out_ready_i;
  assign fire    = (count_q != '0) && load_ok;
  assign sel     = head.closing ? step_q : STEP_VERDICT;
  assign done    = (sel == STEP_VERDICT) || ((sel == STEP_D) && !head.is_final);
  assign pop_o   = fire && done;

  always_comb begin
    res.kind = 1'b0;
    res.ok   = 1'b0;
    res.last = 1'b0;
    unique case (sel)
      STEP_A0: res.idx = head.va;
      STEP_C0, STEP_C1: res.idx = head.vd - IDX_W'(1);
      STEP_B0, STEP_B1: res.idx = head.va + IDX_W'(1);
      STEP_D: begin
        res.idx  = head.vd;
        res.last = !head.is_final;
      end
      STEP_VERDICT: begin
        res.kind = 1'b1;
        res.idx  = '0;
        res.ok   = head.verdict;
        res.last = 1'b1;
      end
      default: res.idx = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q      <= '0;
      rptr_q      <= '0;
      count_q     <= '0;
      step_q      <= STEP_A0;
      out_valid_q <= 1'b0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + FIFO_AW'(1);
      end
      if (pop_o) begin
        rptr_q <= rptr_q + FIFO_AW'(1);
      end
      count_q <= count_q + CRD_W'(push_i) - CRD_W'(pop_o);
      if (fire) begin
        step_q <= done ? STEP_A0 : step_q + 3'd1;
      end
      if (load_ok) begin
        out_valid_q <= fire;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wptr_q] <= job_i;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the grid mesh winding check indexer
// Streams deformed vertex grids through the block and predicts each index and
// verdict transfer. The predictor tracks the line store, the winding sign and
// the failed flag on its own. Every result transfer is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gmw_pkg::*;

  // The slowest correct run stays well under RUN_LIMIT: about 600 vertices,
  // at most 7 transfers each, the slowest receiver, sender gaps and drains.
  localparam int RUN_LIMIT    = 200_000;
  localparam int RANDOM_ITEMS = 340;
  localparam int DRAIN_CYCLES = 12;
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam int CELL_1X1 [6] = '{0, 2, 1, 1, 2, 3};

  typedef enum logic [1:0] {ROW_QUIET, ROW_GOOD, ROW_BAD} row_check_e;
  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_e;
  typedef enum logic [1:0] {NZ_DROP, NZ_WILD, NZ_REPEAT, NZ_MIRROR} noise_e;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    ok;
    row_check_e              check;
  } vertex_row_t;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               cfg_we    = 1'b0;
  reg_idx_e           cfg_index = REG_GRID_COLUMNS;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  logic               s_valid   = 1'b0;
  logic               s_ready;
  logic [2*POS_W-1:0] s_data    = '0;   // pos_x, pos_y
  logic [0:0]         s_user    = '0;   // pos_ok
  logic               m_valid;
  logic               m_ready   = 1'b1;
  logic [15:0]        m_data;           // vertex_index, grid_ok, zero fill
  logic [0:0]         m_user;           // kind
  logic               m_last;

  grid_mesh_winding_check_indexer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tuser  (m_user),
    .m_axis_tlast  (m_last)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state.
  logic [CFG_W-1:0] cols_reg = 7'd1;
  logic [CFG_W-1:0] rows_reg = 7'd1;
  int unsigned      row_n    = 0;
  int unsigned      col_n    = 0;
  logic [IDX_W-1:0] vtx_n    = '0;
  point_t           line_buf [0:COLS_MAX];
  point_t           left_pt;
  point_t           upleft_pt;
  sign_e            wind     = SGN_NONE;
  logic             failed   = 1'b0;

  result_t step_out[$];
  result_t table_due[$];
  result_t due_results[$];

  int errors     = 0;
  int sent       = 0;
  int cycles     = 0;
  int burst_left = 0;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                            input int unsigned lim);
    if (v == '0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic void restart_grid();
    row_n  = 0;
    col_n  = 0;
    vtx_n  = '0;
    wind   = SGN_NONE;
    failed = 1'b0;
  endfunction

  // Sign of (p - o) x (q - o); the products fit easily in 64 bits.
  function automatic int cross_dir(input point_t o, input point_t p, input point_t q);
    longint lhs;
    longint rhs;
    lhs = (longint'(p.x) - longint'(o.x)) * (longint'(q.y) - longint'(o.y));
    rhs = (longint'(p.y) - longint'(o.y)) * (longint'(q.x) - longint'(o.x));
    if (lhs > rhs) return 1;
    if (lhs < rhs) return -1;
    return 0;
  endfunction

  function automatic void note_sign(input int dir);
    sign_e seen;
    if (failed) return;
    if (dir == 0) begin
      failed = 1'b1;
      return;
    end
    seen = (dir > 0) ? SGN_POS : SGN_NEG;
    if (wind != SGN_NONE && wind != seen) failed = 1'b1;
    else wind = seen;
  endfunction

  function automatic void add_result(input logic kind, input logic [IDX_W-1:0] idx,
                                     input logic ok, input logic last);
    result_t r;
    r.kind = kind;
    r.idx  = idx;
    r.ok   = ok;
    r.last = last;
    step_out.push_back(r);
  endfunction

  // Results of one accepted vertex, left in step_out.
  function automatic void triangulate_vertex(input point_t d, input logic ok);
    int unsigned      cols;
    int unsigned      rows;
    int unsigned      col;
    logic             closes_grid;
    logic [IDX_W-1:0] va;
    logic [IDX_W-1:0] vc;
    step_out.delete();
    cols = clamp_dim(cols_reg, COLS_MAX);
    rows = clamp_dim(rows_reg, ROWS_MAX);
    col  = (col_n > cols) ? cols : col_n;
    if (!ok) failed = 1'b1;
    closes_grid = (row_n >= rows) && (col >= cols);
    if (row_n > 0 && col > 0) begin
      vc = vtx_n - IDX_W'(1);
      va = vtx_n - IDX_W'(cols) - IDX_W'(2);
      note_sign(cross_dir(upleft_pt, left_pt, line_buf[col]));
      note_sign(cross_dir(line_buf[col], left_pt, d));
      add_result(1'b0, va, 1'b0, 1'b0);
      add_result(1'b0, vc, 1'b0, 1'b0);
      add_result(1'b0, va + IDX_W'(1), 1'b0, 1'b0);
      add_result(1'b0, va + IDX_W'(1), 1'b0, 1'b0);
      add_result(1'b0, vc, 1'b0, 1'b0);
      add_result(1'b0, vtx_n, 1'b0, !closes_grid);
    end
    if (closes_grid) begin
      add_result(1'b1, '0, !failed, 1'b1);
      restart_grid();
      return;
    end
    upleft_pt     = line_buf[col];
    line_buf[col] = d;
    left_pt       = d;
    vtx_n         = vtx_n + IDX_W'(1);
    if (col >= cols) begin
      col_n = 0;
      row_n = row_n + 1;
    end else begin
      col_n = col + 1;
    end
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    errors++;
    if (errors <= 200)
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, field, got, want);
  endtask

  // Called at a falling edge; returns at a falling edge.
  task automatic send_vertex(input point_t pt, input logic ok, input logic from_table);
    s_valid <= 1'b1;
    s_data  <= pt;
    s_user  <= ok;
    do @(posedge clk_i); while (!s_ready);
    triangulate_vertex(pt, ok);
    if (from_table) step_out = table_due;
    foreach (step_out[i]) due_results.push_back(step_out[i]);
    sent++;
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(0, 10);
    end
  endtask

  task automatic write_reg(input reg_idx_e which, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (which == REG_GRID_COLUMNS) cols_reg = value;
    else rows_reg = value;
    restart_grid();
  endtask

  // Stop sending and wait out every pending transfer plus the pipeline depth.
  task automatic drain();
    s_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic longint spread(input longint m);
    return longint'($urandom_range(0, 32'(2 * m))) - m;
  endfunction

  function automatic logic signed [POS_W-1:0] to_pos(input longint v);
    if (v > longint'(POS_MAX)) return POS_MAX;
    if (v < longint'(POS_MIN)) return POS_MIN;
    return POS_W'(v);
  endfunction

  function automatic logic [CFG_W-1:0] extreme_dim();
    case ($urandom_range(0, 3))
      0:       return CFG_W'(COLS_MAX);
      1:       return CFG_W'(COLS_MAX - 1);
      2:       return CFG_W'(COLS_MAX + 1);
      default: return '1;
    endcase
  endfunction

  // A sheared, jittered lattice keeps every triangle wound the same way, so
  // most grids pass; a few grids carry invalid, wild, repeated or mirrored
  // vertices.
  task automatic lattice_grid(input int ncols, input int nrows, input int nverts);
    longint sx, sy, shx, shy, ax, ay, jit, bx, by, px, py;
    int     noise;
    int     col;
    int     row;
    point_t pt;
    point_t prev;
    logic   ok;
    sx = longint'($urandom_range(1, 4_000_000 / (ncols + 1)));
    sy = longint'($urandom_range(1, 4_000_000 / (nrows + 1)));
    if ($urandom_range(0, 5) == 0) begin
      sx = sx % 8 + 1;
      sy = sy % 8 + 1;
    end
    if ($urandom_range(0, 1) == 1) sx = -sx;
    if ($urandom_range(0, 1) == 1) sy = -sy;
    ax  = (sx < 0) ? -sx : sx;
    ay  = (sy < 0) ? -sy : sy;
    shx = spread(ax / 4);
    shy = spread(ay / 4);
    jit = ((ax < ay) ? ax : ay) / 16;
    bx  = -(longint'(ncols) * sx + longint'(nrows) * shx) / 2 + spread(1_000_000);
    by  = -(longint'(nrows) * sy + longint'(ncols) * shy) / 2 + spread(1_000_000);
    noise = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 12) : 0;
    if ($urandom_range(0, 15) == 0) noise = 100;
    prev = '0;
    for (int k = 0; k < nverts; k++) begin
      col  = k % (ncols + 1);
      row  = k / (ncols + 1);
      px   = bx + longint'(col) * sx + longint'(row) * shx + spread(jit);
      py   = by + longint'(row) * sy + longint'(col) * shy + spread(jit);
      pt.x = to_pos(px);
      pt.y = to_pos(py);
      ok   = 1'b1;
      if ($urandom_range(0, 99) < noise) begin
        case (noise_e'($urandom_range(0, 3)))
          NZ_DROP:   ok = 1'b0;
          NZ_WILD: begin
            pt.x = POS_W'($urandom());
            pt.y = POS_W'($urandom());
          end
          NZ_REPEAT: pt = prev;
          NZ_MIRROR: pt.x = -pt.x;
        endcase
      end
      send_vertex(pt, ok, 1'b0);
      prev = pt;
    end
  endtask

  task automatic new_geometry();
    logic [CFG_W-1:0] c;
    logic [CFG_W-1:0] r;
    int               sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      c = extreme_dim();
      r = CFG_W'($urandom_range(0, 2));
    end else if (sel == 1) begin
      c = CFG_W'($urandom_range(0, 2));
      r = extreme_dim();
    end else begin
      c = CFG_W'($urandom_range(0, 5));
      r = CFG_W'($urandom_range(0, 5));
    end
    // A single write keeps the other register, so only when the grid stays small.
    if ($urandom_range(0, 3) == 0 &&
        clamp_dim(c, COLS_MAX) * clamp_dim(rows_reg, ROWS_MAX) <= 36) begin
      write_reg(REG_GRID_COLUMNS, c);
    end else if ($urandom_range(0, 3) == 0 &&
                 clamp_dim(cols_reg, COLS_MAX) * clamp_dim(r, ROWS_MAX) <= 36) begin
      write_reg(REG_GRID_ROWS, r);
    end else if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_GRID_COLUMNS, c);
      write_reg(REG_GRID_ROWS, r);
    end else begin
      write_reg(REG_GRID_ROWS, r);
      write_reg(REG_GRID_COLUMNS, c);
    end
  endtask

  // Receiver readiness follows a mode that is redrawn whenever rx_left runs out.
  rx_mode_e rx_mode  = RX_OPEN;
  int       rx_left  = 0;
  int       rx_phase = 0;

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 96);
    end else begin
      rx_left--;
    end
    rx_phase++;
    case (rx_mode)
      RX_OPEN:  m_ready <= 1'b1;
      RX_LIGHT: m_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: m_ready <= ($urandom_range(0, 1) == 0);
      RX_BEAT:  m_ready <= (rx_phase % 4 == 0);
    endcase
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected transfer, vertex_index", int'(m_data[IDX_W-1:0]), 0);
      end else begin
        want = due_results.pop_front();
        if (m_user[0] != want.kind)
          report_mismatch("kind", int'(m_user[0]), int'(want.kind));
        if (m_data[IDX_W-1:0] != want.idx)
          report_mismatch("vertex_index", int'(m_data[IDX_W-1:0]), int'(want.idx));
        if (m_data[IDX_W] != want.ok)
          report_mismatch("grid_ok", int'(m_data[IDX_W]), int'(want.ok));
        if (m_last != want.last)
          report_mismatch("last", int'(m_last), int'(want.last));
        if (m_data[15:IDX_W+1] != '0)
          report_mismatch("tdata fill", int'(m_data[15:IDX_W+1]), 0);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    vertex_row_t dir_rows [24];
    result_t     r;
    point_t      pt;
    int          rand_start;
    int          nc;
    int          nr;
    int          nverts;
    int          ngrids;

    // All rows run on the reset geometry of one cell. Each group of four is a
    // grid: extreme corners, collinear corners, an invalid first vertex,
    // disagreeing triangle signs, mirrored winding, an invalid closing vertex.
    dir_rows = '{
      '{POS_MIN, POS_MIN, 1'b1, ROW_QUIET}, '{POS_MAX, POS_MIN, 1'b1, ROW_QUIET},
      '{POS_MIN, POS_MAX, 1'b1, ROW_QUIET}, '{POS_MAX, POS_MAX, 1'b1, ROW_GOOD},
      '{POS_MIN, POS_MIN, 1'b1, ROW_QUIET}, '{24'sd0, 24'sd0, 1'b1, ROW_QUIET},
      '{POS_MAX, POS_MAX, 1'b1, ROW_QUIET}, '{POS_MAX, POS_MIN, 1'b1, ROW_BAD},
      '{24'sd0, 24'sd0, 1'b0, ROW_QUIET},   '{24'sd1, 24'sd0, 1'b1, ROW_QUIET},
      '{24'sd0, 24'sd1, 1'b1, ROW_QUIET},   '{24'sd1, 24'sd1, 1'b1, ROW_BAD},
      '{24'sd0, 24'sd0, 1'b1, ROW_QUIET},   '{24'sd1, 24'sd0, 1'b1, ROW_QUIET},
      '{24'sd0, 24'sd1, 1'b1, ROW_QUIET},   '{-24'sd1, -24'sd1, 1'b1, ROW_BAD},
      '{24'sd0, 24'sd0, 1'b1, ROW_QUIET},   '{-24'sd1, 24'sd0, 1'b1, ROW_QUIET},
      '{24'sd0, 24'sd1, 1'b1, ROW_QUIET},   '{-24'sd1, 24'sd1, 1'b1, ROW_GOOD},
      '{24'sd0, 24'sd0, 1'b1, ROW_QUIET},   '{24'sd1, 24'sd0, 1'b1, ROW_QUIET},
      '{24'sd0, 24'sd1, 1'b1, ROW_QUIET},   '{24'sd1, 24'sd1, 1'b0, ROW_BAD}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      table_due.delete();
      if (dir_rows[i].check != ROW_QUIET) begin
        foreach (CELL_1X1[k]) begin
          r.kind = 1'b0;
          r.idx  = IDX_W'(CELL_1X1[k]);
          r.ok   = 1'b0;
          r.last = 1'b0;
          table_due.push_back(r);
        end
        r.kind = 1'b1;
        r.idx  = '0;
        r.ok   = (dir_rows[i].check == ROW_GOOD);
        r.last = 1'b1;
        table_due.push_back(r);
      end
      pt.x = dir_rows[i].x;
      pt.y = dir_rows[i].y;
      send_vertex(pt, dir_rows[i].ok, 1'b1);
    end

    // Each phase waits for the block to go quiet, sets a new geometry and
    // sends a few grids; the last grid of a phase is sometimes cut short.
    rand_start = sent;
    while (sent - rand_start < RANDOM_ITEMS) begin
      drain();
      new_geometry();
      nc     = clamp_dim(cols_reg, COLS_MAX);
      nr     = clamp_dim(rows_reg, ROWS_MAX);
      nverts = (nc + 1) * (nr + 1);
      ngrids = (nc * nr > 36) ? 1 : $urandom_range(1, 3);
      for (int g = 0; g < ngrids; g++) begin
        if (g == ngrids - 1 && $urandom_range(0, 3) == 0)
          lattice_grid(nc, nr, $urandom_range(1, nverts - 1));
        else
          lattice_grid(nc, nr, nverts);
      end
    end

    drain();

    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
